// ===== hw/rtl/bia_pkg.sv =====
package bia_pkg;

	// Default sizing of the bitmap.
	localparam int ID_COUNT_DEF  = 4096;
	localparam int WORD_BITS_DEF = 32;

	// Identifier that bit position zero maps to after reset.
	localparam logic [15:0] ID_BASE_RESET = 16'd300;

	// Size of the 16-bit identifier space, used to keep grants below 65536.
	localparam logic [16:0] ID_SPACE = 17'h10000;

	// The word scan looks at 2**GROUP_W full flags per cycle.
	localparam int GROUP_W = 4;

	// Width of the first-zero search below; narrower vectors are padded with ones.
	localparam int FZ_W = 64;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_ALLOC   = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	// Index of the lowest zero bit; returns zero when there is none.
	function automatic logic [5:0] first_zero(input logic [FZ_W-1:0] v);
		logic [5:0] idx;
		idx = '0;
		for (int i = FZ_W - 1; i >= 0; i--) begin
			if (!v[i]) begin
				idx = 6'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== hw/rtl/bia_ram.sv =====
module bia_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 128,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/bitmap_id_allocator.sv =====
// First-free identifier allocator. One bit per identifier is kept in a
// single-port-read, single-port-write RAM of WORD_BITS-bit words (1 = in use),
// with a full flag and a written flag per word held in flip-flops. Each input
// beat is one request and gives exactly one output beat: clear marks every
// identifier free by dropping all written flags together (a word that was
// never written since reads as all free, so no clearing pass is needed, also
// not after reset); allocate scans the full flags sixteen words per cycle for
// the lowest word that is not full, reads that word, picks its lowest free bit,
// sets it and returns id_base plus the bit position, or status 1 when no free
// identifier lies below ID_COUNT and below 65536; release checks the
// identifier against id_base and ID_COUNT and clears its bit (status 2 when out
// of range). Requests are handled one at a time. A clear, an unused op code or
// an out-of-range release goes straight from the input beat to the result step;
// a release passes a divide step (offset split into word index, RAM read), a
// modify step (bit picked, word written back) and the result step; an allocate
// scans the groups of 16 words up to the first word that has room, at most
// ceil(ceil(ID_COUNT / WORD_BITS) / 16) groups, which is 8 for the default sizing,
// then passes the modify step and the result step. When every word is full,
// the scan ends after the last group and goes straight to the result step.
// The next request is taken in the cycle after the result is loaded into the
// output register, even while that result still waits for out_ready; a result
// that finds the output register occupied waits until it drains. The id_base
// register is written through the cfg channel, which is always ready, and must
// only be written while no request is in flight.
module bitmap_id_allocator import bia_pkg::*; #(
	parameter int ID_COUNT  = ID_COUNT_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [15:0] id,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] granted_id,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	// Sizing derived from the parameters.
	localparam int WORD_COUNT = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BW         = $clog2(WORD_BITS);
	localparam int PW         = $clog2(ID_COUNT);
	localparam int GRP_N      = 1 << GROUP_W;
	localparam int NGRP       = (WORD_COUNT + GRP_N - 1) / GRP_N;
	localparam int GW         = (NGRP > 1) ? $clog2(NGRP) : 1;

	// Word index of a release offset by reciprocal multiplication. With the
	// shift chosen as offset width plus ceil(log2(WORD_BITS)), the rounded-up
	// reciprocal gives the exact quotient for every offset below 2**PW.
	localparam int DIV_S = PW + BW;
	localparam int DIV_M = ((1 << DIV_S) + WORD_BITS - 1) / WORD_BITS;
	localparam int MW    = DIV_S + 1;
	localparam int PRW   = PW + MW;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_DIV  = 5'b00100,
		S_MOD  = 5'b01000,
		S_RESP = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [15:0]           id_base_q;
	logic [WORD_COUNT-1:0] wvalid_q;   // word written since the last clear
	logic [WORD_COUNT-1:0] full_q;     // every bit of the word in use
	logic [GW-1:0]         grp_q;      // group of full flags under scan

	// Per-request working registers.
	logic [AW-1:0] word_q;
	logic [PW-1:0] pos_q;
	logic          alloc_q;
	status_t       res_status_q;
	logic [15:0]   res_id_q;

	// Output register.
	logic        out_valid_q;
	status_t     status_q;
	logic [15:0] granted_q;

	// RAM port signals.
	logic                 ram_re, ram_we;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

	logic in_acc, resp_load;

	// Release range check.
	logic [16:0] rel_diff;
	logic        rel_ok;

	// Full-flag scan.
	logic [NGRP*GRP_N-1:0]  flags_pad;
	logic [GRP_N-1:0]       grp_flags;
	logic [FZ_W-1:0]        grp_pad;
	logic [5:0]             grp_fz;
	logic                   grp_hit;
	logic                   grp_last;
	logic [GW+GROUP_W-1:0]  scan_word_full;
	logic [AW-1:0]          scan_word;

	// Release word and bit.
	logic [PRW-1:0] div_prod;
	logic [AW-1:0]  div_word;
	logic [PW-1:0]  rel_rem;
	logic [BW-1:0]  rel_bit;

	// Read-modify-write of one word.
	logic [WORD_BITS-1:0] cur_word;
	logic [FZ_W-1:0]      word_pad;
	logic [5:0]           word_fz;
	logic                 word_hit;
	logic [BW-1:0]        alloc_bit;
	logic [BW-1:0]        mod_bit;
	logic [WORD_BITS-1:0] bit_mask;
	logic [16:0]          alloc_pos;
	logic [16:0]          room;
	logic                 alloc_ok;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign resp_load = (state_q == S_RESP) && (!out_valid_q || out_ready);

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign granted_id = granted_q;

	// An identifier is releasable when id_base <= id < id_base + ID_COUNT.
	assign rel_diff = {1'b0, id} - {1'b0, id_base_q};
	assign rel_ok   = (id >= id_base_q) && (rel_diff < 17'(ID_COUNT));

	// Words past the end of the store are padded as full so the scan skips them.
	always_comb begin
		flags_pad                   = '1;
		flags_pad[WORD_COUNT-1:0]   = full_q;
	end

	assign grp_flags = flags_pad[{grp_q, {GROUP_W{1'b0}}} +: GRP_N];

	always_comb begin
		grp_pad              = '1;
		grp_pad[GRP_N-1:0]   = grp_flags;
	end

	assign grp_fz         = first_zero(grp_pad);
	assign grp_hit        = ~&grp_flags;
	assign grp_last       = (grp_q == GW'(NGRP - 1));
	assign scan_word_full = {grp_q, grp_fz[GROUP_W-1:0]};
	assign scan_word      = scan_word_full[AW-1:0];

	assign div_prod = PRW'(pos_q) * PRW'(DIV_M);
	assign div_word = div_prod[DIV_S +: AW];

	assign rel_rem = pos_q - PW'(word_q) * PW'(WORD_BITS);
	assign rel_bit = rel_rem[BW-1:0];

	// A word not written since the last clear holds stale data and reads as free.
	assign cur_word = wvalid_q[word_q] ? ram_rdata : '0;

	always_comb begin
		word_pad                  = '1;
		word_pad[WORD_BITS-1:0]   = cur_word;
	end

	assign word_fz   = first_zero(word_pad);
	assign word_hit  = ~&cur_word;
	assign alloc_bit = word_fz[BW-1:0];
	assign mod_bit   = alloc_q ? alloc_bit : rel_bit;
	assign bit_mask  = WORD_BITS'(1) << mod_bit;

	// The grant must stay below ID_COUNT and keep the identifier within 16 bits.
	assign alloc_pos = 17'(word_q) * 17'(WORD_BITS) + 17'(alloc_bit);
	assign room      = ID_SPACE - {1'b0, id_base_q};
	assign alloc_ok  = word_hit && (alloc_pos < 17'(ID_COUNT)) && (alloc_pos < room);

	assign ram_wdata = alloc_q ? (cur_word | bit_mask) : (cur_word & ~bit_mask);

	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_raddr = scan_word;
		ram_we    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (op == OP_ALLOC) begin
						state_d = S_SCAN;
					end else if (op == OP_RELEASE && rel_ok) begin
						state_d = S_DIV;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_SCAN: begin
				if (grp_hit) begin
					ram_re  = 1'b1;
					state_d = S_MOD;
				end else if (grp_last) begin
					state_d = S_RESP;
				end
			end
			S_DIV: begin
				ram_re    = 1'b1;
				ram_raddr = div_word;
				state_d   = S_MOD;
			end
			S_MOD: begin
				ram_we  = !alloc_q || alloc_ok;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (resp_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			id_base_q   <= ID_BASE_RESET;
			wvalid_q    <= '0;
			full_q      <= '0;
			grp_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				id_base_q <= cfg_data;
			end
			if (in_acc && op == OP_CLEAR) begin
				wvalid_q <= '0;
				full_q   <= '0;
			end
			if (in_acc) begin
				grp_q <= '0;
			end else if (state_q == S_SCAN && !grp_hit && !grp_last) begin
				grp_q <= grp_q + GW'(1);
			end
			if (ram_we) begin
				wvalid_q[word_q] <= 1'b1;
				full_q[word_q]   <= &ram_wdata;
			end
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			alloc_q      <= (op == OP_ALLOC);
			pos_q        <= rel_diff[PW-1:0];
			res_status_q <= (op == OP_RELEASE && !rel_ok) ? ST_INVALID : ST_DONE;
			res_id_q     <= '0;
		end
		if (state_q == S_SCAN) begin
			if (grp_hit) begin
				word_q <= scan_word;
			end else if (grp_last) begin
				res_status_q <= ST_FULL;
			end
		end
		if (state_q == S_DIV) begin
			word_q <= div_word;
		end
		if (state_q == S_MOD && alloc_q) begin
			res_status_q <= alloc_ok ? ST_DONE : ST_FULL;
			res_id_q     <= alloc_ok ? 16'(17'(id_base_q) + alloc_pos) : '0;
		end
		if (resp_load) begin
			status_q  <= res_status_q;
			granted_q <= res_id_q;
		end
	end

	bia_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORD_COUNT),
		.ADDR_W(AW)
	) u_bits (
		.clk  (clk),
		.we   (ram_we),
		.waddr(word_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// A word can only be marked full after it has been written.
	a_full_written: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q & ~wvalid_q) == '0)
		else $error("full flag set on a word that was never written");

	// The scan must only pick a word that still has room.
	a_scan_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && ram_re) |-> !full_q[ram_raddr])
		else $error("scan selected a full word");

	// The bitmap is only written back in the modify step, which then reports.
	a_write_step: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_MOD))
		else $error("bitmap written outside the modify step");

	a_mod_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD) |=> (state_q == S_RESP))
		else $error("modify step not followed by the result step");

	// Only a successful allocate carries a nonzero identifier.
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_DONE) |-> (granted_q == '0))
		else $error("identifier reported with a failing status");

endmodule
